/* rtl/frc_pkg.sv */
// Shared constants and control types for the FIR filter block.
// Used by frc_lane, frc_merge and fir_filter_real_complex; depends on nothing.
package frc_pkg;

  // Default sizes, handed down from the top level
  localparam int MAX_TAPS_DEF     = 32;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF   = 16;

  // Accumulator width, products wrap into it
  localparam int ACC_W = 40;

  // Multiply lanes working side by side (power of two, merge tree is two levels)
  localparam int NUM_LANES = 4;
  localparam int LANE_W    = 2;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_TAP_COUNT    = 1'b0;
  localparam logic REG_COMPLEX_MODE = 1'b1;

  // Input item kinds carried on tuser
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_COEF   = 1'b1;

  // Lane control
  typedef struct packed {
    logic clear;  // zero product and accumulator
    logic mac;    // multiply the taps presented this cycle
    logic acc;    // add the registered product
  } frc_lane_ctrl_t;

  // Merge control
  typedef struct packed {
    logic sum1;   // pairwise lane sums
    logic sum2;   // final total
  } frc_merge_ctrl_t;

endpackage

/* rtl/frc_lane.sv */
// One multiply-accumulate lane: real and imaginary products with a shared coefficient.
// Depends on frc_pkg.
module frc_lane #(
  parameter int SAMPLE_WIDTH = frc_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = frc_pkg::COEF_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  frc_pkg::frc_lane_ctrl_t        ctrl_i,
  input  logic                           tap_ok_i,
  input  logic signed [SAMPLE_WIDTH-1:0] dly_real_i,
  input  logic signed [SAMPLE_WIDTH-1:0] dly_imag_i,
  input  logic signed [COEF_WIDTH-1:0]   coef_i,
  output logic [frc_pkg::ACC_W-1:0]      acc_real_o,
  output logic [frc_pkg::ACC_W-1:0]      acc_imag_o
);
  import frc_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int EXT_W  = (PROD_W > ACC_W) ? PROD_W : ACC_W;

  logic signed [PROD_W-1:0] mul_real, mul_imag;
  logic signed [EXT_W-1:0]  ext_real, ext_imag;
  logic [ACC_W-1:0]         prod_real_q, prod_imag_q;
  logic [ACC_W-1:0]         acc_real_q, acc_imag_q;

  // Full-width signed products, sign extended then wrapped to the accumulator
  assign mul_real = dly_real_i * coef_i;
  assign mul_imag = dly_imag_i * coef_i;
  assign ext_real = EXT_W'(mul_real);
  assign ext_imag = EXT_W'(mul_imag);

  // Product register, then accumulate (modulo 2^ACC_W)
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear || !(ctrl_i.mac && tap_ok_i)) begin
      prod_real_q <= '0;
      prod_imag_q <= '0;
    end else begin
      prod_real_q <= ext_real[ACC_W-1:0];
      prod_imag_q <= ext_imag[ACC_W-1:0];
    end
    if (ctrl_i.clear) begin
      acc_real_q <= '0;
      acc_imag_q <= '0;
    end else if (ctrl_i.acc) begin
      acc_real_q <= acc_real_q + prod_real_q;
      acc_imag_q <= acc_imag_q + prod_imag_q;
    end
  end

  assign acc_real_o = acc_real_q;
  assign acc_imag_o = acc_imag_q;

endmodule

/* rtl/frc_merge.sv */
// Merge stage: sums the lane accumulators over two registered levels, then rounds
// and saturates. Depends on frc_pkg.
module frc_merge #(
  parameter int SAMPLE_WIDTH = frc_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = frc_pkg::COEF_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  frc_pkg::frc_merge_ctrl_t       ctrl_i,
  input  logic                           complex_mode_i,
  input  logic [frc_pkg::ACC_W-1:0]      acc_real_i [frc_pkg::NUM_LANES],
  input  logic [frc_pkg::ACC_W-1:0]      acc_imag_i [frc_pkg::NUM_LANES],
  output logic signed [SAMPLE_WIDTH-1:0] out_real_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_imag_o,
  output logic                           saturated_o
);
  import frc_pkg::*;

  localparam int HALF  = NUM_LANES / 2;
  localparam int RND_W = ACC_W + 1;
  localparam int SH    = COEF_WIDTH - 1;
  localparam logic signed [RND_W-1:0] RND_C = RND_W'(64'sd1 <<< (SH - 1));
  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);

  logic [ACC_W-1:0] s1_real_q [HALF];
  logic [ACC_W-1:0] s1_imag_q [HALF];
  logic [ACC_W-1:0] tot_real_q, tot_imag_q;
  logic [ACC_W-1:0] tot_real_d, tot_imag_d;
  logic [SAMPLE_WIDTH:0] fin_real, fin_imag;

  // Round half up by adding 2^(SH-1), floor shift, clip; returns {clip, value}
  function automatic logic [SAMPLE_WIDTH:0] round_sat(input logic [ACC_W-1:0] acc);
    logic signed [RND_W-1:0] v;
    logic signed [RND_W-1:0] r;
    logic [SAMPLE_WIDTH:0]   res;
    v = $signed({acc[ACC_W-1], acc}) + RND_C;
    r = v >>> SH;
    if (r > SAT_HI) begin
      res = {1'b1, SAT_HI[SAMPLE_WIDTH-1:0]};
    end else if (r < SAT_LO) begin
      res = {1'b1, SAT_LO[SAMPLE_WIDTH-1:0]};
    end else begin
      res = {1'b0, r[SAMPLE_WIDTH-1:0]};
    end
    return res;
  endfunction

  // Second level: add the pair sums
  always_comb begin
    tot_real_d = '0;
    tot_imag_d = '0;
    for (int i = 0; i < HALF; i++) begin
      tot_real_d = tot_real_d + s1_real_q[i];
      tot_imag_d = tot_imag_d + s1_imag_q[i];
    end
  end

  // Registered adder tree
  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum1) begin
      for (int i = 0; i < HALF; i++) begin
        s1_real_q[i] <= acc_real_i[2*i] + acc_real_i[2*i+1];
        s1_imag_q[i] <= acc_imag_i[2*i] + acc_imag_i[2*i+1];
      end
    end
    if (ctrl_i.sum2) begin
      tot_real_q <= tot_real_d;
      tot_imag_q <= tot_imag_d;
    end
  end

  assign fin_real = round_sat(tot_real_q);
  assign fin_imag = round_sat(tot_imag_q);

  // Imaginary result and its clip flag only count in complex mode
  assign out_real_o  = $signed(fin_real[SAMPLE_WIDTH-1:0]);
  assign out_imag_o  = complex_mode_i ? $signed(fin_imag[SAMPLE_WIDTH-1:0]) : '0;
  assign saturated_o = fin_real[SAMPLE_WIDTH] | (complex_mode_i & fin_imag[SAMPLE_WIDTH]);

endmodule

/* rtl/fir_filter_real_complex.sv */
// Direct-form FIR filter, real coefficients, real or complex Q1.15 stream.
// Top level: delay lines, coefficient store, sequencer, config port.
// Depends on frc_pkg, frc_lane and frc_merge.

// A sample item (tuser = 0) shifts into both delay lines and yields one
// filtered result; a coefficient item (tuser = 1) with an index below MAX_TAPS
// writes one tap and clears the delay lines, leaves the block idle and gives no
// result. A sample item keeps the block busy while four multiply lanes sweep the
// delay line four taps per cycle, then through the drain state, the adder-tree
// states SUM1 and SUM2 and the round/saturate stage into the output register.
// Results wait in that register, so the next item can be accepted while a
// result is still pending. Register 0 (address 0) is tap_count, 0 acts
// as one tap and values above MAX_TAPS as MAX_TAPS; register 1 (address 4) is
// complex_mode. Write registers only while the block is idle.
module fir_filter_real_complex #(
  parameter int MAX_TAPS     = frc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = frc_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = frc_pkg::COEF_WIDTH_DEF,
  localparam int IDX_W       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
  localparam int IN_W        = ((2 * SAMPLE_WIDTH + IDX_W + COEF_WIDTH + 7) / 8) * 8,
  localparam int OUT_W       = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sample_real, sample_imag, coef_index, coef_value (low to high)
  input  logic [IN_W-1:0]                   s_axis_tdata,
  // action
  input  logic                              s_axis_tuser,
  // Result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_real, out_imag (low to high)
  output logic [OUT_W-1:0]                  m_axis_tdata,
  // saturated
  output logic                              m_axis_tuser,
  // Configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [frc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [frc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [frc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import frc_pkg::*;

  localparam int STEPS     = (MAX_TAPS + NUM_LANES - 1) / NUM_LANES;
  localparam int PAD       = STEPS * NUM_LANES;
  localparam int STEP_W    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CMP_W     = STEP_W + LANE_W + 1;
  localparam int TAP_CNT_W = $clog2(MAX_TAPS + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MAC    = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_SUM1   = 6'b001000,
    ST_SUM2   = 6'b010000,
    ST_FINISH = 6'b100000
  } frc_state_e;

  frc_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic [TAP_CNT_W-1:0] tap_count_q;
  logic                 complex_mode_q;
  logic [TAP_CNT_W-1:0] taps_eff;

  logic signed [SAMPLE_WIDTH-1:0] dly_real_q [PAD];
  logic signed [SAMPLE_WIDTH-1:0] dly_imag_q [PAD];
  logic signed [COEF_WIDTH-1:0]   coef_q [PAD];

  logic                           in_acc;
  logic signed [SAMPLE_WIDTH-1:0] in_real, in_imag;
  logic [IDX_W-1:0]               in_idx;
  logic signed [COEF_WIDTH-1:0]   in_coef;
  logic                           coef_wr, sample_go, rotate;

  frc_lane_ctrl_t  lane_ctrl;
  frc_merge_ctrl_t merge_ctrl;
  logic [NUM_LANES-1:0] tap_ok;
  logic [ACC_W-1:0] acc_real [NUM_LANES];
  logic [ACC_W-1:0] acc_imag [NUM_LANES];

  logic signed [SAMPLE_WIDTH-1:0] mrg_real, mrg_imag;
  logic                           mrg_sat;
  logic                           out_load;
  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_real_q, out_imag_q;
  logic                           out_sat_q;

  // Unpack the input item
  assign in_real = $signed(s_axis_tdata[SAMPLE_WIDTH-1:0]);
  assign in_imag = $signed(s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
  assign in_idx  = s_axis_tdata[2*SAMPLE_WIDTH+IDX_W-1:2*SAMPLE_WIDTH];
  assign in_coef = $signed(s_axis_tdata[2*SAMPLE_WIDTH+IDX_W+COEF_WIDTH-1:
                                        2*SAMPLE_WIDTH+IDX_W]);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign sample_go     = in_acc & (s_axis_tuser == ACT_SAMPLE);
  assign coef_wr       = in_acc & (s_axis_tuser == ACT_COEF) &
                         ({1'b0, in_idx} < (IDX_W + 1)'(MAX_TAPS));
  assign rotate        = (state_q == ST_MAC);

  // Effective tap count
  always_comb begin
    if (tap_count_q == '0) begin
      taps_eff = TAP_CNT_W'(1);
    end else if (tap_count_q > TAP_CNT_W'(MAX_TAPS)) begin
      taps_eff = TAP_CNT_W'(MAX_TAPS);
    end else begin
      taps_eff = tap_count_q;
    end
  end

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q    <= TAP_CNT_W'(MAX_TAPS);
      complex_mode_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_TAP_COUNT:    tap_count_q    <= pwdata[TAP_CNT_W-1:0];
        REG_COMPLEX_MODE: complex_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TAP_COUNT:    prdata = APB_DATA_W'(tap_count_q);
      REG_COMPLEX_MODE: prdata = APB_DATA_W'(complex_mode_q);
      default:          prdata = '0;
    endcase
  end

  // Delay lines shift on a sample; lines and coefficients rotate by one lane group
  // per sweep step (a full sweep restores them); a coef write clears the lines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PAD; k++) begin
        dly_real_q[k] <= '0;
        dly_imag_q[k] <= '0;
        coef_q[k]     <= '0;
      end
    end else if (coef_wr) begin
      for (int k = 0; k < PAD; k++) begin
        dly_real_q[k] <= '0;
        dly_imag_q[k] <= '0;
      end
      for (int k = 0; k < MAX_TAPS; k++) begin
        if (in_idx == IDX_W'(k)) begin
          coef_q[k] <= in_coef;
        end
      end
    end else if (sample_go) begin
      dly_real_q[0] <= in_real;
      dly_imag_q[0] <= in_imag;
      for (int k = 1; k < PAD; k++) begin
        dly_real_q[k] <= dly_real_q[k-1];
        dly_imag_q[k] <= dly_imag_q[k-1];
      end
    end else if (rotate) begin
      for (int k = 0; k < PAD; k++) begin
        dly_real_q[k] <= dly_real_q[(k + NUM_LANES) % PAD];
        dly_imag_q[k] <= dly_imag_q[(k + NUM_LANES) % PAD];
        coef_q[k]     <= coef_q[(k + NUM_LANES) % PAD];
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (sample_go) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(STEPS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_SUM1;
      ST_SUM1:   state_d = ST_SUM2;
      ST_SUM2:   state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Lane and merge controls
  assign lane_ctrl.clear  = sample_go;
  assign lane_ctrl.mac    = (state_q == ST_MAC);
  assign lane_ctrl.acc    = (state_q == ST_MAC) || (state_q == ST_DRAIN);
  assign merge_ctrl.sum1  = (state_q == ST_SUM1);
  assign merge_ctrl.sum2  = (state_q == ST_SUM2);

  // Lanes: lane l always sees tap position l of the rotating lines
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    assign tap_ok[l] = ((CMP_W'(step_q) << LANE_W) | CMP_W'(l)) < CMP_W'(taps_eff);

    frc_lane #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
    ) u_lane (
      .clk_i     (clk_i),
      .ctrl_i    (lane_ctrl),
      .tap_ok_i  (tap_ok[l]),
      .dly_real_i(dly_real_q[l]),
      .dly_imag_i(dly_imag_q[l]),
      .coef_i    (coef_q[l]),
      .acc_real_o(acc_real[l]),
      .acc_imag_o(acc_imag[l])
    );
  end

  frc_merge #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_merge (
    .clk_i         (clk_i),
    .ctrl_i        (merge_ctrl),
    .complex_mode_i(complex_mode_q),
    .acc_real_i    (acc_real),
    .acc_imag_i    (acc_imag),
    .out_real_o    (mrg_real),
    .out_imag_o    (mrg_imag),
    .saturated_o   (mrg_sat)
  );

  // Output register
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_real_q <= mrg_real;
      out_imag_q <= mrg_imag;
      out_sat_q  <= mrg_sat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_imag_q, out_real_q});
  assign m_axis_tuser  = out_sat_q;

endmodule
